FILE: rtl/lorg_pkg.sv
// Shared types and constants for the log-odds ray grid update block.
`default_nettype none
package lorg_pkg;
    localparam int GRID_BITS  = 8;                   // 256 x 256 cells
    localparam int ADDR_BITS  = 2 * GRID_BITS;
    localparam int CELL_COUNT = 1 << ADDR_BITS;
    localparam int FRAC_BITS  = 12;
    localparam int VAL_BITS   = 16;
    localparam int WORD_BITS  = VAL_BITS + 1;        // value plus observed bit
    localparam logic signed [17:0] CAP_VALUE =
        ((4 << FRAC_BITS) > 32767) ? 18'sd32767 : 18'(4 << FRAC_BITS);
    localparam logic [15:0] STEP_MAX = 16'd32768;

    typedef enum logic [1:0] {
        ACT_RAY    = 2'd0,
        ACT_DECAY  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_OCC_UPDATE  = 2'd0,
        REG_FREE_UPDATE = 2'd1,
        REG_FLOOR       = 2'd2,
        REG_DECAY       = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RAY,
        S_DECAY,
        S_READ,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/lorg_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module lorg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/log_odds_ray_grid_update.sv
// Top level: log-odds occupancy grid with Bresenham ray, decay and read actions.
`default_nettype none
// One word in, one word out. The grid (256 x 256 cells of Q3.12 log-odds and an
// observed bit) lives in one RAM with a registered read; every update is a
// read-modify-write pipelined at one cell per cycle. After reset the block zeroes
// the RAM and takes no input word meanwhile (config writes are taken). A ray
// covers N cells on the line (at most 256); decay walks all 65536 cells (and is
// skipped if the step is zero); a read fetches one cell. The next word is taken
// only once the current one is finished, though a finished result may still wait
// on m_axis_tready.
module log_odds_ray_grid_update (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24],
    // hit[32], elapsed_ticks[48:33], zero fill [55:49]
    input  wire logic [55:0] s_axis_tdata,
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cell_value[15:0], cell_observed[16], zero fill [23:17]
    output logic      [23:0] m_axis_tdata
);
    import lorg_pkg::*;

    // config registers
    logic [14:0]        r_occ_upd;
    logic [14:0]        r_free_upd;
    logic signed [15:0] r_floor;
    logic [11:0]        r_decay;

    t_state r_state, n_state;

    logic [ADDR_BITS-1:0] r_addr;
    logic [GRID_BITS-1:0] r_x, r_y, r_ex, r_ey;
    logic                 r_sx_pos, r_sy_pos, r_hit;
    logic signed [9:0]    r_dx, r_dy;
    logic signed [10:0]   r_err;
    logic                 r_iss_done;
    logic [15:0]          r_step;
    t_action              r_act;

    // read-modify-write stage
    logic                 r_p_valid, r_p_last, r_p_occ;
    logic [ADDR_BITS-1:0] r_p_addr;

    logic signed [15:0] r_res_value;
    logic               r_res_obs;
    logic               r_out_valid;
    logic [23:0]        r_out_data;

    // RAM ports
    logic                 wr_en, rd_en;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;
    logic [WORD_BITS-1:0] wr_data, rd_data;

    lorg_ram #(.WIDTH(WORD_BITS), .DEPTH(CELL_COUNT)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // input fields
    t_action              in_act;
    logic [GRID_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
    logic                 in_hit;
    logic [15:0]          in_ticks;
    logic [27:0]          in_prod;
    logic                 accept;

    assign in_act   = t_action'(s_axis_tuser);
    assign in_sx    = s_axis_tdata[7:0];
    assign in_sy    = s_axis_tdata[15:8];
    assign in_ex    = s_axis_tdata[23:16];
    assign in_ey    = s_axis_tdata[31:24];
    assign in_hit   = s_axis_tdata[32];
    assign in_ticks = s_axis_tdata[48:33];
    assign in_prod  = 28'(r_decay) * 28'(in_ticks);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Bresenham step
    logic               cur_last, step_x, step_y;
    logic signed [11:0] twice;
    logic signed [10:0] err_nx;
    assign cur_last = (r_x == r_ex) && (r_y == r_ey);
    assign twice    = {r_err, 1'b0};
    assign step_x   = twice >= 12'(r_dy);
    assign step_y   = twice <= 12'(r_dx);
    assign err_nx   = r_err + (step_x ? 11'(r_dy) : 11'sd0) + (step_y ? 11'(r_dx) : 11'sd0);

    // cell update arithmetic
    logic signed [15:0] cur_val;
    logic               cur_obs;
    logic signed [17:0] v_ext, t_free, t_occ, t_dn, t_up, step_ext;
    logic signed [15:0] new_val;
    logic               new_obs;

    assign cur_val  = signed'(rd_data[15:0]);
    assign cur_obs  = rd_data[16];
    assign v_ext    = 18'(cur_val);
    assign step_ext = signed'({2'b00, r_step});
    assign t_free   = v_ext - signed'({3'b000, r_free_upd});
    assign t_occ    = v_ext + signed'({3'b000, r_occ_upd});
    assign t_dn     = v_ext - step_ext;
    assign t_up     = v_ext + step_ext;

    always_comb begin
        new_val = cur_val;
        new_obs = cur_obs;
        if (r_act == ACT_DECAY) begin
            if (cur_obs) begin
                if (cur_val > 16'sd0) begin
                    new_val = (t_dn < 18'sd0) ? 16'sd0 : t_dn[15:0];
                end else begin
                    new_val = (t_up > 18'sd0) ? 16'sd0 : t_up[15:0];
                end
            end
        end else begin
            new_obs = 1'b1;
            if (r_p_occ) begin
                new_val = (t_occ > CAP_VALUE) ? CAP_VALUE[15:0] : t_occ[15:0];
            end else begin
                new_val = (t_free < 18'(r_floor)) ? r_floor : t_free[15:0];
            end
        end
    end

    logic out_free, stage_end;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign stage_end = r_p_valid && r_p_last;

    // RAM port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_p_addr;
        wr_data = {new_obs, new_val};
        rd_en   = 1'b0;
        rd_addr = {r_y, r_x};
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
            end
            S_RAY: begin
                rd_en = !r_iss_done;
                wr_en = r_p_valid;
            end
            S_DECAY: begin
                rd_en   = !r_iss_done;
                rd_addr = r_addr;
                wr_en   = r_p_valid;
            end
            S_READ: rd_en = !r_iss_done;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (in_act)
                        ACT_RAY:    n_state = S_RAY;
                        ACT_DECAY:  n_state = (in_prod == '0) ? S_DONE : S_DECAY;
                        ACT_READ:   n_state = S_READ;
                        ACT_UNUSED: n_state = S_DONE;
                    endcase
                end
            end
            S_RAY, S_DECAY, S_READ: if (stage_end) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_upd  <= 15'd3482;
            r_free_upd <= 15'd1638;
            r_floor    <= -16'sd8192;
            r_decay    <= 12'd0;
        end else if (i_cfg_valid && (i_cfg_index[7:2] == '0)) begin
            unique case (t_reg_index'(i_cfg_index[1:0]))
                REG_OCC_UPDATE:  r_occ_upd  <= i_cfg_data[14:0];
                REG_FREE_UPDATE: r_free_upd <= i_cfg_data[14:0];
                REG_FLOOR:       r_floor    <= signed'(i_cfg_data);
                REG_DECAY:       r_decay    <= i_cfg_data[11:0];
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_p_valid   <= 1'b0;
            r_iss_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_p_valid <= ((r_state == S_RAY) || (r_state == S_READ) || (r_state == S_DECAY))
                         && !r_iss_done;
            unique case (r_state)
                S_CLEAR: r_addr <= r_addr + 1'b1;
                S_IDLE: begin
                    r_addr     <= '0;
                    r_iss_done <= 1'b0;
                end
                S_RAY, S_READ: begin
                    if (!r_iss_done && (r_state == S_READ || cur_last)) r_iss_done <= 1'b1;
                end
                S_DECAY: begin
                    if (!r_iss_done) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == '1) r_iss_done <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act       <= in_act;
            r_x         <= in_sx;
            r_y         <= in_sy;
            r_ex        <= in_ex;
            r_ey        <= in_ey;
            r_hit       <= in_hit;
            r_sx_pos    <= in_sx < in_ex;
            r_sy_pos    <= in_sy < in_ey;
            r_dx        <= (in_ex > in_sx) ? 10'(in_ex - in_sx) : 10'(in_sx - in_ex);
            r_dy        <= (in_ey > in_sy) ? -10'(in_ey - in_sy) : -10'(in_sy - in_ey);
            r_err       <= ((in_ex > in_sx) ? 11'(in_ex - in_sx) : 11'(in_sx - in_ex))
                         - ((in_ey > in_sy) ? 11'(in_ey - in_sy) : 11'(in_sy - in_ey));
            r_step      <= (in_prod > 28'(STEP_MAX)) ? STEP_MAX : in_prod[15:0];
            r_res_value <= '0;
            r_res_obs   <= 1'b0;
        end
        if (r_state == S_RAY && !r_iss_done) begin
            r_p_addr <= {r_y, r_x};
            r_p_last <= cur_last;
            r_p_occ  <= cur_last && r_hit;
            if (!cur_last) begin
                r_err <= err_nx;
                if (step_x) r_x <= r_sx_pos ? r_x + 1'b1 : r_x - 1'b1;
                if (step_y) r_y <= r_sy_pos ? r_y + 1'b1 : r_y - 1'b1;
            end
        end
        if (r_state == S_DECAY && !r_iss_done) begin
            r_p_addr <= r_addr;
            r_p_last <= (r_addr == '1);
            r_p_occ  <= 1'b0;
        end
        if (r_state == S_READ && !r_iss_done) begin
            r_p_addr <= {r_y, r_x};
            r_p_last <= 1'b1;
            r_p_occ  <= 1'b0;
        end
        if (stage_end) begin
            if (r_state == S_RAY) begin
                r_res_value <= new_val;
                r_res_obs   <= 1'b1;
            end else if (r_state == S_READ) begin
                r_res_value <= cur_val;
                r_res_obs   <= cur_obs;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= {7'b0, r_res_obs, r_res_value};
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb_log_odds_ray_grid_checker.sv
// Checker for the log-odds ray grid block: predicts each result and compares it.
`timescale 1ns / 1ps
module tb_log_odds_ray_grid_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_in_user,
    input  wire logic [55:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_out_data,
    output int               o_fail_count,
    output int               o_pending
);
    import lorg_pkg::*;

    typedef struct packed {
        logic signed [15:0] value;
        logic               observed;
    } t_cell_result;

    logic signed [VAL_BITS-1:0] grid_value [CELL_COUNT];
    bit                         grid_seen  [CELL_COUNT];
    t_cell_result               expected_cells [$];

    int occ_step;
    int free_step;
    int floor_level;
    int decay_rate;

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            grid_value[i] = '0;
            grid_seen[i]  = 1'b0;
        end
        occ_step     = 3482;
        free_step    = 1638;
        floor_level  = -8192;
        decay_rate   = 0;
        o_fail_count = 0;
    end

    assign o_pending = expected_cells.size();

    function automatic int cell_addr(int x, int y);
        return y * (1 << GRID_BITS) + x;
    endfunction

    function automatic void touch_cell(int x, int y, bit occupied);
        int a;
        int v;
        a = cell_addr(x, y);
        v = grid_value[a];
        if (occupied) begin
            v += occ_step;
            if (v > int'(CAP_VALUE)) v = int'(CAP_VALUE);
        end else begin
            v -= free_step;
            if (v < floor_level) v = floor_level;
        end
        grid_value[a] = 16'(v);
        grid_seen[a]  = 1'b1;
    endfunction

    function automatic void trace_ray(int x0, int y0, int x1, int y1, bit occupied);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int twice;
        dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
        sx  = (x0 < x1) ? 1 : -1;
        sy  = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        while (!(x0 == x1 && y0 == y1)) begin
            touch_cell(x0, y0, 1'b0);
            twice = 2 * err;
            if (twice >= dy) begin
                err += dy;
                x0  += sx;
            end
            if (twice <= dx) begin
                err += dx;
                y0  += sy;
            end
        end
        touch_cell(x1, y1, occupied);
    endfunction

    function automatic void decay_grid(int ticks);
        longint step;
        int v;
        step = longint'(decay_rate) * ticks;
        if (step == 0) return;
        if (step > STEP_MAX) step = STEP_MAX;
        for (int i = 0; i < CELL_COUNT; i++) begin
            if (grid_seen[i]) begin
                v = grid_value[i];
                if (v > 0) begin
                    v -= int'(step);
                    if (v < 0) v = 0;
                end else begin
                    v += int'(step);
                    if (v > 0) v = 0;
                end
                grid_value[i] = 16'(v);
            end
        end
    endfunction

    function automatic t_cell_result predict_cell(logic [1:0] u, logic [55:0] w);
        t_action      act;
        int           sx;
        int           sy;
        int           ex;
        int           ey;
        t_cell_result r;
        act = t_action'(u);
        sx  = w[7:0];
        sy  = w[15:8];
        ex  = w[23:16];
        ey  = w[31:24];
        r   = '0;
        case (act)
            ACT_RAY: begin
                trace_ray(sx, sy, ex, ey, w[32]);
                r.value    = grid_value[cell_addr(ex, ey)];
                r.observed = grid_seen[cell_addr(ex, ey)];
            end
            ACT_DECAY: decay_grid(int'(w[48:33]));
            ACT_READ: begin
                r.value    = grid_value[cell_addr(sx, sy)];
                r.observed = grid_seen[cell_addr(sx, sy)];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result want;
        int           bad;
        bad = 0;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    8'(REG_OCC_UPDATE):  occ_step    = i_cfg_data[14:0];
                    8'(REG_FREE_UPDATE): free_step   = i_cfg_data[14:0];
                    8'(REG_FLOOR):       floor_level = $signed(i_cfg_data);
                    8'(REG_DECAY):       decay_rate  = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_cells.push_back(predict_cell(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_cells.size() == 0) begin
                    $error("result word with nothing expected: %h", i_out_data);
                    bad++;
                end else begin
                    want = expected_cells.pop_front();
                    if (i_out_data[15:0] !== want.value) begin
                        $error("cell_value expected %0d got %0d", want.value,
                               $signed(i_out_data[15:0]));
                        bad++;
                    end
                    if (i_out_data[16] !== want.observed) begin
                        $error("cell_observed expected %0d got %0d", want.observed,
                               i_out_data[16]);
                        bad++;
                    end
                    if (i_out_data[23:17] !== '0) begin
                        $error("fill bits expected 0 got %h", i_out_data[23:17]);
                        bad++;
                    end
                end
            end
            if (bad != 0) o_fail_count <= o_fail_count + bad;
        end
    end
endmodule

FILE: tb/tb_log_odds_ray_grid_update.sv
// Testbench top: stimulus, receiver stalls and verdict for the log-odds ray grid block.
`timescale 1ns / 1ps
module tb_log_odds_ray_grid_update;
    import lorg_pkg::*;

    localparam int          CYCLE_LIMIT = 5_000_000;
    localparam logic [7:0]  REG_NONE    = 8'd200;   // no such register

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    int fail_count;
    int pending;
    int cycles;
    int stall_left;
    bit gaps_on;
    int slow_decays;   // decays with a nonzero step walk the whole grid

    log_odds_ray_grid_update DUT (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    tb_log_odds_ray_grid_checker checker_inst (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_user(s_axis_tuser), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_log_odds_ray_grid_update NOT OK");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] occ, logic [15:0] free, logic [15:0] flr,
                            logic [15:0] rate);
        wait_drained();
        write_reg(8'(REG_OCC_UPDATE), occ);
        write_reg(8'(REG_FREE_UPDATE), free);
        write_reg(8'(REG_FLOOR), flr);
        write_reg(8'(REG_DECAY), rate);
    endtask

    task automatic send_word(t_action act, logic [7:0] sx, logic [7:0] sy,
                             logic [7:0] ex, logic [7:0] ey, logic hit,
                             logic [15:0] ticks);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'b0, ticks, hit, ey, ex, sy, sx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // most coordinates land in a small patch so cells build up and saturate
    function automatic logic [7:0] pick_coord();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_words(int count, bit rate_zero);
        int          pick;
        t_action     act;
        logic [15:0] ticks;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(0, 99);
            ticks = 16'($urandom_range(0, 65535));
            if (pick < 60) act = ACT_RAY;
            else if (pick < 65) act = ACT_DECAY;
            else if (pick < 97) act = ACT_READ;
            else act = ACT_UNUSED;
            if (act == ACT_DECAY && !rate_zero) begin
                if (slow_decays < 8) begin
                    slow_decays++;
                    ticks = 16'($urandom_range(1, 40));
                end else begin
                    ticks = '0;
                end
            end
            send_word(act, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      1'($urandom_range(0, 1)), ticks);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        stall_left    = 0;
        gaps_on       = 1'b1;
        slow_decays   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings first
        send_word(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_word(ACT_RAY, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 16'hFFFF);
        send_word(ACT_RAY, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 16'd0);
        send_word(ACT_RAY, 8'd3, 8'd3, 8'd3, 8'd3, 1'b1, 16'd0);      // single cell
        send_word(ACT_RAY, 8'd10, 8'd2, 8'd0, 8'd9, 1'b1, 16'd0);
        send_word(ACT_RAY, 8'd0, 8'd200, 8'd255, 8'd201, 1'b0, 16'd0);
        send_word(ACT_READ, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 16'd0);
        send_word(ACT_READ, 8'd128, 8'd128, 8'd0, 8'd0, 1'b0, 16'd0);  // on the diagonal ray
        send_word(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
        send_word(ACT_DECAY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'hFFFF);  // rate zero
        for (int k = 0; k < 6; k++)
            send_word(ACT_RAY, 8'd1, 8'd1, 8'd5, 8'd1, 1'b0, 16'd0);   // down to floor
        for (int k = 0; k < 6; k++)
            send_word(ACT_RAY, 8'd5, 8'd7, 8'd7, 8'd7, 1'b1, 16'd0);   // up to the cap

        set_regs(16'd2000, 16'd1000, 16'h8000, 16'd4095);
        write_reg(REG_NONE, 16'hFFFF);
        send_word(ACT_DECAY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd1);
        send_word(ACT_READ, 8'd7, 8'd7, 8'd0, 8'd0, 1'b0, 16'd0);
        send_word(ACT_DECAY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'hFFFF);  // saturated step
        send_word(ACT_READ, 8'd1, 8'd1, 8'd0, 8'd0, 1'b0, 16'd0);
        send_word(ACT_DECAY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0);     // zero ticks
        slow_decays = 2;

        set_regs(16'd3482, 16'd1638, 16'hE000, 16'd100);
        random_words(400, 1'b0);
        set_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'd0);
        random_words(300, 1'b1);
        set_regs(16'd0, 16'd0, 16'h0000, 16'd4095);
        random_words(200, 1'b0);
        set_regs(16'd700, 16'd300, 16'h7FFF, 16'd0);                   // positive floor
        random_words(200, 1'b1);
        set_regs(16'd5000, 16'd900, 16'hC000, 16'd0);
        gaps_on = 1'b0;
        random_words(400, 1'b1);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_log_odds_ray_grid_update OK");
        end else begin
            $display("tb_log_odds_ray_grid_update NOT OK");
        end
        $finish;
    end
endmodule
